### src/lbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpt_pkg: shared types and functions for the LED blink pattern timer
// Payload structs, mode codes, per-LED state and the command/tick update rules.
// ----------------------------------------------------------------------------
package lbpt_pkg;

  // width of the period and on-time fields at the ports
  localparam int unsigned FIELD_W = 16;
  // width of the per-LED timers
  localparam int unsigned TIMER_W = 16;

  typedef logic [TIMER_W-1:0] tmr_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam tmr_t TMAX    = '1;
  localparam tmr_t TMAX_M1 = TMAX - tmr_t'(1);
  localparam tmr_t ON_TIME_MIN = tmr_t'(2);

  // period and on time applied with the saved mode when a single blink finishes
  localparam field_t ONCE_RELOAD_PERIOD  = field_t'(1000);
  localparam field_t ONCE_RELOAD_ON_TIME = field_t'(500);

  localparam logic FUNC_TICK     = 1'b0;
  localparam logic FUNC_SET_MODE = 1'b1;

  localparam logic LED_SEL_STATE = 1'b0;
  localparam logic LED_SEL_NET   = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_ONCE   = 2'd2,
    MODE_REPEAT = 2'd3
  } mode_e;

  typedef struct packed {
    logic       func;
    logic       led_select;
    logic [1:0] mode;
    field_t     period;
    field_t     on_time;
  } in_item_t;

  typedef struct packed {
    logic state_lit;
    logic net_lit;
  } out_item_t;

  typedef struct packed {
    mode_e cur_mode;
    mode_e saved_mode;
    tmr_t  reload_value;
    tmr_t  countdown;
    tmr_t  off_point;
    logic  led_level;
  } led_state_t;

  // mode change: loads period/off point (not ONCE over ONCE); keeps LED level
  function automatic led_state_t led_apply(led_state_t s, mode_e md,
                                           field_t per_in, field_t on_in);
    led_state_t r;
    tmr_t       per;
    tmr_t       p;
    tmr_t       on;
    logic       load;
    r    = s;
    per  = (33'(per_in) > 33'(TMAX_M1)) ? TMAX_M1 : tmr_t'(per_in);
    p    = per + tmr_t'(1);
    on   = (33'(on_in) > 33'(TMAX)) ? TMAX : tmr_t'(on_in);
    load = 1'b0;
    case (md)
      MODE_OFF: begin
        p = tmr_t'(1);
        on = tmr_t'(1);
        r.saved_mode = MODE_OFF;
        load = 1'b1;
      end
      MODE_ON: begin
        p = tmr_t'(2);
        on = tmr_t'(2);
        r.saved_mode = MODE_ON;
        load = 1'b1;
      end
      MODE_ONCE: begin
        if (on < ON_TIME_MIN) on = ON_TIME_MIN;
        else if (on > p) on = p;
        // a single blink already running swallows the command
        if (s.cur_mode != MODE_ONCE) begin
          r.saved_mode = s.cur_mode;
          load = 1'b1;
        end
      end
      default: begin
        if (on < ON_TIME_MIN) on = ON_TIME_MIN;
        else if (on > p) on = p;
        load = 1'b1;
      end
    endcase
    if (load) begin
      r.cur_mode     = md;
      r.reload_value = p;
      r.countdown    = p;
      r.off_point    = p - on;
    end
    return r;
  endfunction

  // one millisecond step of a single LED
  function automatic led_state_t led_tick(led_state_t s);
    led_state_t r;
    tmr_t       cnt;
    r   = s;
    cnt = s.countdown - tmr_t'(1);
    if (s.countdown != '0) begin
      r.countdown = cnt;
      if (cnt == '0) begin
        case (s.cur_mode)
          MODE_OFF:  r.led_level = 1'b0;
          MODE_ON:   r.led_level = 1'b1;
          MODE_ONCE: r = led_apply(r, s.saved_mode, ONCE_RELOAD_PERIOD,
                                   ONCE_RELOAD_ON_TIME);
          default:   r.countdown = s.reload_value;
        endcase
      end else if (cnt == s.off_point) begin
        r.led_level = 1'b0;
      end else if (cnt == s.reload_value - tmr_t'(1)) begin
        r.led_level = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

### src/led_blink_pattern_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_pattern_timer: two-LED blink pattern timer
// Ticks and mode commands drive a state LED and a network LED; every transfer
// in yields one transfer out carrying both LED levels.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//  out     | output    | out_valid_o/ out_stall_i| out_data_o (out_item_t)
//
//  one item per cycle while the output is not stalled; its result appears
//  in the cycle after the transfer in; the per-LED compare/decrement logic
//  sits between the state registers and a single output register
//  reset clears all LED state to off with stopped countdowns
//  input stalls only while the output register holds a result that is stalled
// ----------------------------------------------------------------------------
module led_blink_pattern_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lbpt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbpt_pkg::out_item_t out_data_o
);
  import lbpt_pkg::*;

  led_state_t led_q [2];
  led_state_t led_d [2];
  logic       out_valid_q, out_valid_d;
  out_item_t  out_data_q, out_data_d;
  logic       in_xfer;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  for (genvar g = 0; g < 2; g++) begin : g_led
    lbpt_led u_led (
      .st_q_i   (led_q[g]),
      .tick_en_i(in_xfer && (in_data_i.func == FUNC_TICK)),
      .cmd_en_i (in_xfer && (in_data_i.func == FUNC_SET_MODE) &&
                 (in_data_i.led_select == ((g == 0) ? LED_SEL_STATE : LED_SEL_NET))),
      .item_i   (in_data_i),
      .st_d_o   (led_d[g])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    if (in_xfer) begin
      out_valid_d          = 1'b1;
      out_data_d.state_lit = led_d[0].led_level;
      out_data_d.net_lit   = led_d[1].led_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        led_q[i] <= '{cur_mode: MODE_OFF, saved_mode: MODE_OFF, reload_value: '0,
                      countdown: '0, off_point: '0, led_level: 1'b0};
      end
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      led_q[0]    <= led_d[0];
      led_q[1]    <= led_d[1];
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // every transfer in leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("result missing after input transfer");

  // input is held back only by a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // result shows the LED levels the item left behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (out_data_o.state_lit == led_q[0].led_level) &&
                (out_data_o.net_lit == led_q[1].led_level))
    else $error("result does not match LED state");

  // without a transfer in, LED state stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(led_q[0]) && $stable(led_q[1]))
    else $error("LED state changed without a transfer");

endmodule

### src/lbpt_led.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpt_led: next-state logic of one LED channel
// Applies a mode command or a tick to the registered state of one LED.
// ----------------------------------------------------------------------------
module lbpt_led (
  input  lbpt_pkg::led_state_t st_q_i,
  input  logic                 tick_en_i,
  input  logic                 cmd_en_i,
  input  lbpt_pkg::in_item_t   item_i,
  output lbpt_pkg::led_state_t st_d_o
);
  import lbpt_pkg::*;

  always_comb begin
    st_d_o = st_q_i;
    if (tick_en_i) begin
      st_d_o = led_tick(st_q_i);
    end else if (cmd_en_i) begin
      st_d_o = led_apply(st_q_i, mode_e'(item_i.mode), item_i.period, item_i.on_time);
    end
  end

endmodule
